### rtl/vlbg_pkg.sv
// Shared types and constants for the voxel line and box generator.
// Used by every module of the block; depends on nothing else.

package vlbg_pkg;

    localparam int MAX_CELLS = 64;
    localparam int CNT_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int DIM_W     = $clog2(MAX_CELLS + 1);
    localparam int COORD_W   = 16;
    localparam int ERR_W     = 19;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [1:0] FUNC_LINE  = 2'd0;
    localparam logic [1:0] FUNC_SOLID = 2'd1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        JOB_LINE,
        JOB_SOLID,
        JOB_HOLLOW,
        JOB_BIG
    } t_job_kind;

    typedef struct packed {
        t_job_kind                    kind;
        logic [1:0]                   drv;
        logic [2:0]                   st_neg;
        logic [2:0][COORD_W-1:0]      p0;
        logic [2:0][COORD_W-1:0]      p1;
        logic [2:0][COORD_W-1:0]      ad;
        logic [2:0][ERR_W-1:0]        err;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DELTA,
        F_PLAN,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_back_state;

endpackage

### rtl/vlbg_front.sv
// Front end: accepts a request, computes deltas, driving axis, error terms,
// sorted corners and the box volume check, then pushes one job. Uses vlbg_pkg.

module vlbg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [2:0][vlbg_pkg::COORD_W-1:0] i_start,
    input  logic [2:0][vlbg_pkg::COORD_W-1:0] i_end,
    input  vlbg_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output vlbg_pkg::t_job                o_job
);
    import vlbg_pkg::*;

    t_front_state r_state, n_state;

    logic [1:0]                r_func;
    logic [2:0][COORD_W-1:0]   r_a, r_b;
    logic [2:0][COORD_W-1:0]   r_ad, r_lo, r_hi;
    logic [2:0]                r_stn, r_dimbig;
    logic [2:0][DIM_W-1:0]     r_dim;
    logic [1:0]                r_drv;
    logic [2:0][ERR_W-1:0]     r_err;
    logic [2*DIM_W-1:0]        r_p01;
    logic                      r_anybig;

    logic [2:0][COORD_W:0]     w_dl;
    logic [2:0][COORD_W-1:0]   w_ad, w_lo, w_hi, w_span;
    logic [2:0]                w_stn, w_dimbig;
    logic [2:0][DIM_W-1:0]     w_dim;
    logic [1:0]                w_drv;
    logic [COORD_W-1:0]        w_ad_d;
    logic [2:0][ERR_W-1:0]     w_err;
    logic [3*DIM_W-1:0]        w_vol;
    logic                      w_big;

    // Per-axis delta, direction, magnitude and sorted span
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dl[i]  = {r_b[i][COORD_W-1], r_b[i]} - {r_a[i][COORD_W-1], r_a[i]};
            w_stn[i] = w_dl[i][COORD_W] || (w_dl[i] == '0);
            w_ad[i]  = w_dl[i][COORD_W] ? COORD_W'(-w_dl[i]) : w_dl[i][COORD_W-1:0];
            if ($signed(r_a[i]) < $signed(r_b[i])) begin
                w_lo[i] = r_a[i];
                w_hi[i] = r_b[i];
            end else begin
                w_lo[i] = r_b[i];
                w_hi[i] = r_a[i];
            end
            w_span[i]   = w_hi[i] - w_lo[i];
            w_dimbig[i] = w_span[i] >= COORD_W'(MAX_CELLS);
            w_dim[i]    = w_span[i][DIM_W-1:0] + DIM_W'(1);
        end
    end

    // Driving axis: largest delta, ties to x then y
    always_comb begin
        if (r_ad[0] >= r_ad[1] && r_ad[0] >= r_ad[2]) begin
            w_drv = AXIS_X;
        end else if (r_ad[1] >= r_ad[2]) begin
            w_drv = AXIS_Y;
        end else begin
            w_drv = AXIS_Z;
        end
        case (w_drv)
            AXIS_X:  w_ad_d = r_ad[0];
            AXIS_Y:  w_ad_d = r_ad[1];
            default: w_ad_d = r_ad[2];
        endcase
        for (int i = 0; i < 3; i++) begin
            w_err[i] = {2'b00, r_ad[i], 1'b0} - {3'b000, w_ad_d};
        end
    end

    assign w_vol = (3*DIM_W)'(r_p01) * (3*DIM_W)'(r_dim[2]);
    assign w_big = r_anybig || (w_vol > (3*DIM_W)'(MAX_CELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_a    <= i_start;
            r_b    <= i_end;
        end
        if (r_state == F_DELTA) begin
            r_ad     <= w_ad;
            r_stn    <= w_stn;
            r_lo     <= w_lo;
            r_hi     <= w_hi;
            r_dimbig <= w_dimbig;
            r_dim    <= w_dim;
        end
        if (r_state == F_PLAN) begin
            r_drv    <= w_drv;
            r_err    <= w_err;
            r_p01    <= (2*DIM_W)'(r_dim[0]) * (2*DIM_W)'(r_dim[1]);
            r_anybig <= |r_dimbig;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_DELTA;
            F_DELTA: n_state = F_PLAN;
            F_PLAN:  n_state = F_PUSH;
            F_PUSH:  if (!i_q_status.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_PUSH) && !i_q_status.full;
    end

    always_comb begin
        if (r_func == FUNC_LINE) begin
            o_job.kind = JOB_LINE;
        end else if (w_big) begin
            o_job.kind = JOB_BIG;
        end else if (r_func == FUNC_SOLID) begin
            o_job.kind = JOB_SOLID;
        end else begin
            o_job.kind = JOB_HOLLOW;
        end
        o_job.drv    = r_drv;
        o_job.st_neg = r_stn;
        o_job.p0     = (r_func == FUNC_LINE) ? r_a : r_lo;
        o_job.p1     = r_hi;
        o_job.ad     = r_ad;
        o_job.err    = r_err;
    end

endmodule

### rtl/vlbg_queue.sv
// Small job queue between front end and back end, held in flip-flops.
// Uses t_job and queue constants from vlbg_pkg.

module vlbg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  vlbg_pkg::t_job       i_job,
    input  logic                 i_pop,
    output vlbg_pkg::t_job       o_job,
    output vlbg_pkg::t_q_status  o_status
);
    import vlbg_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_PTR_W'(1);
            if (i_pop)  r_rp <= r_rp + Q_PTR_W'(1);
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job          = r_mem[r_rp];
    assign o_status.full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

### rtl/vlbg_back.sv
// Back end: loads a job and walks it, one voxel per cycle, into an output
// register that holds results while the sink stalls. Uses vlbg_pkg.

module vlbg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vlbg_pkg::t_q_status           i_q_status,
    input  vlbg_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0][vlbg_pkg::COORD_W-1:0] o_cell,
    output logic                          o_last,
    output logic                          o_too_large
);
    import vlbg_pkg::*;

    t_back_state r_state, n_state;

    t_job_kind                 r_kind;
    logic [1:0]                r_drv;
    logic [2:0]                r_stn;
    logic [2:0][COORD_W-1:0]   r_pos, r_lo, r_hi, r_ad;
    logic [2:0][ERR_W-1:0]     r_err;
    logic [COORD_W-1:0]        r_rem;
    logic [CNT_W-1:0]          r_cnt;

    logic                      r_ovalid, r_olast, r_obig;
    logic [2:0][COORD_W-1:0]   r_ocell;

    logic                      w_out_free, w_emit, w_last;
    logic [COORD_W-1:0]        w_ad_d;
    logic [2:0][COORD_W-1:0]   w_step, w_line_pos, w_box_pos;
    logic [2:0][ERR_W-1:0]     w_line_err;
    logic                      w_yz_shell;

    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        case (r_drv)
            AXIS_X:  w_ad_d = r_ad[0];
            AXIS_Y:  w_ad_d = r_ad[1];
            default: w_ad_d = r_ad[2];
        endcase
    end

    // One Bresenham step on all three axes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_step[i] = r_stn[i] ? r_pos[i] - COORD_W'(1) : r_pos[i] + COORD_W'(1);
            if (r_drv == 2'(i)) begin
                w_line_pos[i] = w_step[i];
                w_line_err[i] = r_err[i];
            end else if (!r_err[i][ERR_W-1]) begin
                w_line_pos[i] = w_step[i];
                w_line_err[i] = r_err[i] - {2'b00, w_ad_d, 1'b0} + {2'b00, r_ad[i], 1'b0};
            end else begin
                w_line_pos[i] = r_pos[i];
                w_line_err[i] = r_err[i] + {2'b00, r_ad[i], 1'b0};
            end
        end
    end

    // Box scan: x innermost, then z, then y; hollow rows off the shell jump
    // straight from the low x face to the high x face
    always_comb begin
        w_yz_shell = (r_pos[1] == r_lo[1]) || (r_pos[1] == r_hi[1]) ||
                     (r_pos[2] == r_lo[2]) || (r_pos[2] == r_hi[2]);
        w_box_pos = r_pos;
        if (r_pos[0] == r_hi[0]) begin
            w_box_pos[0] = r_lo[0];
            if (r_pos[2] == r_hi[2]) begin
                w_box_pos[2] = r_lo[2];
                w_box_pos[1] = r_pos[1] + COORD_W'(1);
            end else begin
                w_box_pos[2] = r_pos[2] + COORD_W'(1);
            end
        end else if (r_kind == JOB_HOLLOW && !w_yz_shell && r_pos[0] == r_lo[0]) begin
            w_box_pos[0] = r_hi[0];
        end else begin
            w_box_pos[0] = r_pos[0] + COORD_W'(1);
        end
    end

    always_comb begin
        case (r_kind)
            JOB_LINE: w_last = (r_rem == '0) || (r_cnt == CNT_W'(MAX_CELLS - 1));
            JOB_BIG:  w_last = 1'b1;
            default:  w_last = (r_pos == r_hi);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_job.kind;
            r_drv  <= i_job.drv;
            r_stn  <= i_job.st_neg;
            r_pos  <= i_job.p0;
            r_lo   <= i_job.p0;
            r_hi   <= i_job.p1;
            r_ad   <= i_job.ad;
            r_err  <= i_job.err;
            r_cnt  <= '0;
            case (i_job.drv)
                AXIS_X:  r_rem <= i_job.ad[0];
                AXIS_Y:  r_rem <= i_job.ad[1];
                default: r_rem <= i_job.ad[2];
            endcase
        end else if (w_emit) begin
            r_rem <= r_rem - COORD_W'(1);
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_kind == JOB_LINE) begin
                r_pos <= w_line_pos;
                r_err <= w_line_err;
            end else begin
                r_pos <= w_box_pos;
            end
        end
        if (w_emit) begin
            r_olast <= w_last;
            r_obig  <= (r_kind == JOB_BIG);
            r_ocell <= (r_kind == JOB_BIG) ? '0 : r_pos;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_status.empty) n_state = B_RUN;
            B_RUN:   if (w_emit && w_last) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == B_IDLE) && !i_q_status.empty;
        w_emit = (r_state == B_RUN) && w_out_free;
    end

    assign o_valid     = r_ovalid;
    assign o_cell      = r_ocell;
    assign o_last      = r_olast;
    assign o_too_large = r_obig;

endmodule

### rtl/voxel_line_and_box_generator.sv
// Voxel line and box generator: a request carries a mode and two 3D points.
// Line mode walks a 3D Bresenham line from start to end, emitting the start
// cell and one cell per step on the axis of largest delta, at most 64 cells.
// Box modes emit every cell (solid) or every shell cell (hollow, also mode 3)
// of the box spanned by the two corners, in y, z, x loop order; a box of more
// than 64 cells gives one result with too_large set and zero coordinates.
// tlast marks the final result of each request. The front end sets up each
// request in its idle, delta, plan and push states and hands jobs through a
// two-entry queue; the back end loads a job and then emits one result per
// cycle while the sink accepts (at most 64 results per request), and the
// front end can set up the next request meanwhile.

module voxel_line_and_box_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (16 bits each, signed)
    input  logic [95:0]  s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cell_x, cell_y, cell_z (16 bits each, signed)
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    // too_large
    output logic [0:0]   m_axis_tuser
);
    import vlbg_pkg::*;

    logic [2:0][COORD_W-1:0] w_start, w_end, w_cell;
    t_job                    w_push_job, w_pop_job;
    t_q_status               w_q_status;
    logic                    w_push, w_pop, w_too_large;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_start[i] = s_axis_tdata[i*COORD_W +: COORD_W];
            w_end[i]   = s_axis_tdata[(i+3)*COORD_W +: COORD_W];
        end
    end

    vlbg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (s_axis_tuser),
        .i_start    (w_start),
        .i_end      (w_end),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    vlbg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    vlbg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_cell      (w_cell),
        .o_last      (m_axis_tlast),
        .o_too_large (w_too_large)
    );

    assign m_axis_tdata    = {w_cell[2], w_cell[1], w_cell[0]};
    assign m_axis_tuser[0] = w_too_large;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_status.empty))
        else $error("job popped from an empty queue");

    a_big_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("oversized box result without tlast");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("front end ready again right after a transaction");

endmodule

### test/tb_top.sv
// Self-checking testbench for voxel_line_and_box_generator: drives line and box
// requests over the input stream and checks every voxel on the output stream.
// Depends on vlbg_pkg and the generator RTL only.

module tb_top;
    import vlbg_pkg::*;

    localparam logic [1:0] FUNC_HOLLOW = 2'd2;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 150;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
        logic   big;
    } t_voxel;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // start_x, start_y, start_z, end_x, end_y, end_z (16 bits each, signed)
    logic [95:0]  s_axis_tdata = '0;
    // func
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // cell_x, cell_y, cell_z (16 bits each, signed)
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tlast;
    // too_large
    logic [0:0]   m_axis_tuser;

    t_voxel pending_voxels[$];
    int     err_count = 0;
    int     result_count = 0;
    int     idle_cycles = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;
    int     sink_hold = 0;

    voxel_line_and_box_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [2:0][15:0] point3(input int x, input int y, input int z);
        point3 = {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic void push_voxel(input int x, input int y, input int z,
                                       input logic big);
        t_voxel v;
        v.x    = t_coord'(x);
        v.y    = t_coord'(y);
        v.z    = t_coord'(z);
        v.last = 1'b0;
        v.big  = big;
        pending_voxels.push_back(v);
    endfunction

    // Append the voxels that one request produces, the final one flagged last.
    function automatic void plan_voxels(input logic [1:0] func,
                                        input logic [2:0][15:0] p0,
                                        input logic [2:0][15:0] p1);
        int     a[3], b[3], pos[3], ad[3], stp[3], err[3], lo[3], hi[3];
        int     i, k, n, drv, x, y, z;
        longint vol;
        logic   hollow;
        t_voxel tail;
        for (i = 0; i < 3; i++) begin
            a[i] = int'($signed(p0[i]));
            b[i] = int'($signed(p1[i]));
        end
        if (func == FUNC_LINE) begin
            for (i = 0; i < 3; i++) begin
                pos[i] = a[i];
                stp[i] = (b[i] > a[i]) ? 1 : -1;
                ad[i]  = (b[i] > a[i]) ? b[i] - a[i] : a[i] - b[i];
            end
            if (ad[0] >= ad[1] && ad[0] >= ad[2])
                drv = 0;
            else if (ad[1] >= ad[2])
                drv = 1;
            else
                drv = 2;
            for (i = 0; i < 3; i++)
                err[i] = 2 * ad[i] - ad[drv];
            push_voxel(pos[0], pos[1], pos[2], 1'b0);
            n = 1;
            for (k = 0; k < ad[drv] && n < MAX_CELLS; k++) begin
                for (i = 0; i < 3; i++) begin
                    if (i != drv) begin
                        if (err[i] >= 0) begin
                            pos[i] += stp[i];
                            err[i] -= 2 * ad[drv];
                        end
                        err[i] += 2 * ad[i];
                    end
                end
                pos[drv] += stp[drv];
                push_voxel(pos[0], pos[1], pos[2], 1'b0);
                n++;
            end
        end else begin
            hollow = (func != FUNC_SOLID);
            vol = 1;
            for (i = 0; i < 3; i++) begin
                lo[i] = (a[i] < b[i]) ? a[i] : b[i];
                hi[i] = (a[i] < b[i]) ? b[i] : a[i];
                vol *= longint'(hi[i] - lo[i] + 1);
            end
            if (vol > MAX_CELLS) begin
                push_voxel(0, 0, 0, 1'b1);
            end else begin
                for (y = lo[1]; y <= hi[1]; y++)
                    for (z = lo[2]; z <= hi[2]; z++)
                        for (x = lo[0]; x <= hi[0]; x++) begin
                            // drop interior cells of a shell
                            if (!hollow || x == lo[0] || x == hi[0] || y == lo[1] ||
                                y == hi[1] || z == lo[2] || z == hi[2])
                                push_voxel(x, y, z, 1'b0);
                        end
            end
        end
        tail = pending_voxels.pop_back();
        tail.last = 1'b1;
        pending_voxels.push_back(tail);
    endfunction

    // Offer one request; returns at the edge where it is accepted, valid left high.
    task automatic send_request(input logic [1:0] func,
                                input logic [2:0][15:0] p0,
                                input logic [2:0][15:0] p1);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p1, p0};
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        plan_voxels(func, p0, p1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_voxels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_request();
        logic [1:0]       func;
        logic [2:0][15:0] p0, p1;
        int               roll, i, span, axis;
        roll = $urandom_range(99);
        func = (roll < 50) ? FUNC_LINE : 2'($urandom_range(1, 3));
        for (i = 0; i < 3; i++)
            p0[i] = 16'($urandom);
        axis = $urandom_range(2);
        for (i = 0; i < 3; i++) begin
            if (roll < 40)
                p1[i] = p0[i] + 16'($urandom_range(140)) - 16'd70;
            else if (roll < 50 || roll >= 93)
                p1[i] = 16'($urandom);
            else begin
                if (roll < 85)
                    span = $urandom_range(4);
                else
                    span = (i == axis) ? $urandom_range(70) : $urandom_range(1);
                p1[i] = $urandom_range(1) ? p0[i] + 16'(span) : p0[i] - 16'(span);
            end
        end
        send_request(func, p0, p1);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_request();
        wait_drained();
    endtask

    task automatic test_directed_shapes();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // lines: zero length, each driving axis, ties, cut walks, extremes
        send_request(FUNC_LINE, point3(0, 0, 0), point3(0, 0, 0));
        send_request(FUNC_LINE, point3(0, 0, 0), point3(10, 3, -4));
        send_request(FUNC_LINE, point3(5, 5, 5), point3(2, -20, 9));
        send_request(FUNC_LINE, point3(-3, 1, 2), point3(1, -2, 30));
        send_request(FUNC_LINE, point3(0, 0, 0), point3(7, 7, 7));
        send_request(FUNC_LINE, point3(0, 0, 0), point3(2, -9, 9));
        send_request(FUNC_LINE, point3(0, 0, 0), point3(-6, 6, 1));
        send_request(FUNC_LINE, point3(0, 0, 0), point3(63, 5, 0));
        send_request(FUNC_LINE, point3(0, 0, 0), point3(64, 0, 0));
        send_request(FUNC_LINE, point3(-32768, -32768, -32768),
                     point3(32767, 32767, 32767));
        send_request(FUNC_LINE, point3(32767, 0, -32768), point3(-32768, 100, 32767));
        send_request(FUNC_LINE, point3(32760, -32760, 0), point3(32767, -32767, 3));
        // boxes: unit, full capacity, one over, whole range, shells, spare mode
        send_request(FUNC_SOLID, point3(-32768, 32767, -1), point3(-32768, 32767, -1));
        send_request(FUNC_SOLID, point3(3, 3, 3), point3(0, 0, 0));
        send_request(FUNC_SOLID, point3(0, 0, 0), point3(64, 0, 0));
        send_request(FUNC_SOLID, point3(-32768, -32768, -32768),
                     point3(32767, 32767, 32767));
        send_request(FUNC_SOLID, point3(32767, 32767, 32767), point3(32764, 32764, 32767));
        send_request(FUNC_HOLLOW, point3(0, 0, 0), point3(3, 3, 3));
        send_request(FUNC_HOLLOW, point3(1, -1, 1), point3(-1, 1, -1));
        send_request(FUNC_HOLLOW, point3(10, 20, 30), point3(11, 24, 35));
        send_request(FUNC_HOLLOW, point3(-32768, -32768, -32768),
                     point3(-32768, -32761, -32761));
        send_request(FUNC_HOLLOW, point3(0, 0, 0), point3(4, 4, 2));
        send_request(FUNC_SPARE, point3(2, 2, 2), point3(0, 0, 0));
        send_request(FUNC_SPARE, point3(0, 0, 0), point3(100, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_no_idle();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_random(18);
    endtask

    task automatic test_random_source_gaps();
        src_idle_pct = 50;
        sink_stall_pct = 0;
        run_random(18);
    endtask

    task automatic test_random_sink_stalls();
        src_idle_pct = 0;
        sink_stall_pct = 50;
        run_random(18);
    endtask

    task automatic test_random_mixed_idle();
        src_idle_pct = 36;
        sink_stall_pct = 36;
        run_random(18);
    endtask

    // Hold the output off long enough that the input stalls, then let it drain.
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold = HOLD_CYCLES;
        run_random(12);
    endtask

    // Result side: check each transaction, then pick the next ready.
    always @(posedge i_clk) begin
        t_voxel got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.x    = t_coord'(m_axis_tdata[15:0]);
            got.y    = t_coord'(m_axis_tdata[31:16]);
            got.z    = t_coord'(m_axis_tdata[47:32]);
            got.last = m_axis_tlast;
            got.big  = m_axis_tuser[0];
            if (pending_voxels.size() == 0) begin
                report_error($sformatf("unexpected voxel %0d: x=%0d y=%0d z=%0d",
                                       result_count, got.x, got.y, got.z));
            end else begin
                want = pending_voxels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.last !== want.last || got.big !== want.big)
                    report_error($sformatf(
                        "voxel %0d: got %0d,%0d,%0d last=%b big=%b want %0d,%0d,%0d last=%b big=%b",
                        result_count, got.x, got.y, got.z, got.last, got.big,
                        want.x, want.y, want.z, want.last, want.big));
            end
            result_count++;
        end
        if (sink_hold > 0)
            sink_hold--;
        m_axis_tready <= i_rst_n && (sink_hold == 0) &&
                         ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_shapes();
        test_random_no_idle();
        test_random_source_gaps();
        test_random_sink_stalls();
        test_random_mixed_idle();
        test_output_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/vlbg_pkg.sv
rtl/vlbg_front.sv
rtl/vlbg_queue.sv
rtl/vlbg_back.sv
rtl/voxel_line_and_box_generator.sv
test/tb_top.sv
